@@ hdl/bpa_pkg.sv @@
// Shared types and constants of the buddy page allocator.
// Used by every module of the block but bpa_ram; depends on nothing.
`default_nettype none

package bpa_pkg;

  // Fixed field widths of the request and result transfers.
  localparam int unsigned KIND_W  = 1;
  localparam int unsigned ORDER_W = 4;
  localparam int unsigned PAGE_W  = 12;

  // Free bits are stored in memory words of this many bits.
  localparam int unsigned WORD_AW = 6;
  localparam int unsigned WORD_W  = 1 << WORD_AW;

  localparam logic [KIND_W-1:0] KIND_ALLOC = 1'b0;
  localparam logic [KIND_W-1:0] KIND_FREE  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_ORDER = 2'd1,
    ST_NO_MEM    = 2'd2,
    ST_BAD_FREE  = 2'd3
  } bpa_status_e;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [ORDER_W-1:0] order;
    logic [PAGE_W-1:0]  block_index;
  } bpa_req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [PAGE_W-1:0]  page_index;
    logic [ORDER_W-1:0] result_order;
  } bpa_rsp_t;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_LOAD,
    DP_CLR_STEP,
    DP_READ,
    DP_SCAN_NEXT,
    DP_FOUND,
    DP_SPLIT,
    DP_SET_BUDDY,
    DP_FCHK_INIT,
    DP_FCHK_NEXT,
    DP_MERGE_INIT,
    DP_CLR_BUDDY,
    DP_SET_SELF,
    DP_RES_OK,
    DP_RES_ERR
  } bpa_op_e;

  typedef struct packed {
    bpa_op_e     op;
    bpa_status_e err;
  } bpa_cmd_t;

  typedef struct packed {
    logic bad_order;
    logic is_free_req;
    logic bad_free;
    logic m_over;
    logic m_at_ord;
    logic m_at_max;
    logic word_nz;
    logic hit;
    logic row_end;
    logic buddy_free;
    logic clr_last;
    logic out_free;
  } bpa_sts_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_A_RD,
    S_A_CHK,
    S_SPLIT,
    S_SPL_RD,
    S_SPL_WR,
    S_F_RD,
    S_F_CHK,
    S_M_TEST,
    S_M_CHK,
    S_M_RD,
    S_M_SET,
    S_OK,
    S_ERR
  } bpa_state_e;

endpackage

`default_nettype wire

@@ hdl/bpa_ram.sv @@
// Generic RAM with separate write and read addresses, one write and one registered read.
// Stand-alone; depends on nothing.
`default_nettype none

module bpa_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 704,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ hdl/bpa_datapath.sv @@
// Datapath of the buddy page allocator: request registers, order and position
// counters, the free-bit memory and the result register. Uses bpa_pkg, bpa_ram.
`default_nettype none

module bpa_datapath import bpa_pkg::*; #(
  parameter int unsigned MAX_ORDER = 10,
  parameter int unsigned NUM_PAGES = 4096
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire bpa_req_t in_data_i,
  input  wire bpa_cmd_t cmd_i,
  input  wire logic     out_ready_i,
  output bpa_sts_t      sts_o,
  output logic          out_valid_o,
  output bpa_rsp_t      out_data_o
);

  localparam int unsigned PW         = $clog2(NUM_PAGES);
  localparam int unsigned RW         = PW - WORD_AW;
  localparam int unsigned OW         = $clog2(MAX_ORDER + 2);
  localparam int unsigned DEPTH      = (MAX_ORDER + 1) << RW;
  localparam int unsigned AW         = $clog2(DEPTH);
  localparam int unsigned TOP_BLOCKS = NUM_PAGES >> MAX_ORDER;

  logic [KIND_W-1:0] kind_q;
  logic [OW-1:0]     ord_q;
  logic [PAGE_W-1:0] page_q;
  logic              bad_order_q;
  logic [OW-1:0]     m_q, m_d;
  logic [PW-1:0]     pos_q, pos_d;
  logic              out_valid_q, out_valid_d;
  bpa_rsp_t          out_q, out_d;

  logic [RW-1:0]      row;
  logic [WORD_AW-1:0] bit_sel;
  logic [WORD_AW-1:0] buddy_sel;
  logic [AW-1:0]      addr;
  logic [31:0]        blocks;
  logic [RW-1:0]      last_row;
  logic [31:0]        base;
  logic [31:0]        span;
  logic [31:0]        size;
  logic [RW-1:0]      end_row;
  logic [WORD_W-1:0]  mask;
  logic [WORD_W-1:0]  rdata;
  logic [WORD_W-1:0]  wdata;
  logic [WORD_W-1:0]  init_word;
  logic [WORD_AW-1:0] pe;
  logic               we;
  logic               re;
  logic               m_at_max;

  assign row       = pos_q[PW-1:WORD_AW];
  assign bit_sel   = pos_q[WORD_AW-1:0];
  assign buddy_sel = {bit_sel[WORD_AW-1:1], ~bit_sel[0]};
  assign addr      = AW'({m_q, row});
  assign m_at_max  = (32'(m_q) == MAX_ORDER);

  // Rows of the current order that can hold a block.
  assign blocks   = 32'(NUM_PAGES) >> m_q;
  assign last_row = (blocks == 32'd0) ? '0 : RW'((blocks - 32'd1) >> WORD_AW);

  // Bits at the current order that overlap the block being freed.
  assign base    = 32'(page_q) >> m_q;
  assign span    = (m_q >= ord_q) ? 32'd1 : (32'd1 << (ord_q - m_q));
  assign end_row = RW'((base + span - 32'd1) >> WORD_AW);
  assign size    = 32'd1 << ord_q;

  always_comb begin
    if (span >= 32'(WORD_W)) begin
      mask = '1;
    end else begin
      mask = ((WORD_W'(1) << span) - WORD_W'(1)) << bit_sel;
    end
  end

  always_comb begin
    pe = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (rdata[i]) begin
        pe = WORD_AW'(i);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < WORD_W; i++) begin
      init_word[i] = m_at_max && (32'({row, WORD_AW'(i)}) < TOP_BLOCKS);
    end
  end

  always_comb begin
    m_d         = m_q;
    pos_d       = pos_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    we          = 1'b0;
    re          = 1'b0;
    wdata       = rdata;
    case (cmd_i.op)
      DP_LOAD: begin
        m_d   = OW'(in_data_i.order);
        pos_d = '0;
      end
      DP_CLR_STEP: begin
        we    = 1'b1;
        wdata = init_word;
        pos_d = pos_q + PW'(WORD_W);
        if (row == '1) begin
          m_d = m_q + OW'(1);
        end
      end
      DP_READ: begin
        re = 1'b1;
      end
      DP_SCAN_NEXT: begin
        if (row == last_row) begin
          m_d   = m_q + OW'(1);
          pos_d = '0;
        end else begin
          pos_d = pos_q + PW'(WORD_W);
        end
      end
      DP_FOUND: begin
        we        = 1'b1;
        wdata[pe] = 1'b0;
        pos_d     = {row, pe};
      end
      DP_SPLIT: begin
        m_d   = m_q - OW'(1);
        pos_d = {pos_q[PW-2:0], 1'b0};
      end
      DP_SET_BUDDY: begin
        we               = 1'b1;
        wdata[buddy_sel] = 1'b1;
      end
      DP_FCHK_INIT: begin
        m_d   = '0;
        pos_d = PW'(page_q);
      end
      DP_FCHK_NEXT: begin
        if (row == end_row) begin
          m_d   = m_q + OW'(1);
          pos_d = PW'(32'(page_q) >> (m_q + OW'(1)));
        end else begin
          pos_d = pos_q + PW'(WORD_W);
        end
      end
      DP_MERGE_INIT: begin
        m_d   = ord_q;
        pos_d = PW'(32'(page_q) >> ord_q);
      end
      DP_CLR_BUDDY: begin
        we               = 1'b1;
        wdata[buddy_sel] = 1'b0;
        m_d              = m_q + OW'(1);
        pos_d            = pos_q >> 1;
      end
      DP_SET_SELF: begin
        we             = 1'b1;
        wdata[bit_sel] = 1'b1;
      end
      DP_RES_OK: begin
        out_valid_d        = 1'b1;
        out_d.status       = ST_OK;
        out_d.page_index   = PAGE_W'(32'(pos_q) << m_q);
        out_d.result_order = ORDER_W'(m_q);
      end
      DP_RES_ERR: begin
        out_valid_d        = 1'b1;
        out_d.status       = cmd_i.err;
        out_d.page_index   = '0;
        out_d.result_order = '0;
      end
      default: begin
      end
    endcase
  end

  bpa_ram #(
    .WIDTH(WORD_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(addr),
    .wdata_i(wdata),
    .re_i   (re),
    .raddr_i(addr),
    .rdata_o(rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_q         <= '0;
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      m_q         <= m_d;
      pos_q       <= pos_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    if (cmd_i.op == DP_LOAD) begin
      kind_q      <= in_data_i.kind;
      ord_q       <= OW'(in_data_i.order);
      page_q      <= in_data_i.block_index;
      bad_order_q <= (32'(in_data_i.order) > MAX_ORDER);
    end
  end

  always_comb begin
    sts_o.bad_order   = bad_order_q;
    sts_o.is_free_req = (kind_q == KIND_FREE);
    sts_o.bad_free    = ((32'(page_q) & (size - 32'd1)) != 32'd0) ||
                        ((32'(page_q) + size) > NUM_PAGES);
    sts_o.m_over      = (32'(m_q) > MAX_ORDER);
    sts_o.m_at_ord    = (m_q == ord_q);
    sts_o.m_at_max    = m_at_max;
    sts_o.word_nz     = |rdata;
    sts_o.hit         = |(rdata & mask);
    sts_o.row_end     = (row == end_row);
    sts_o.buddy_free  = rdata[buddy_sel];
    sts_o.clr_last    = m_at_max && (row == '1);
    sts_o.out_free    = !out_valid_q || out_ready_i;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

@@ hdl/bpa_ctrl.sv @@
// Controller state machine of the buddy page allocator.
// Uses bpa_pkg; drives the datapath by command and reads its status.
`default_nettype none

module bpa_ctrl import bpa_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  input  wire bpa_sts_t sts_i,
  output logic          in_ready_o,
  output bpa_cmd_t      cmd_o
);

  bpa_state_e  state_q, state_d;
  bpa_status_e err_q, err_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      err_q   <= ST_OK;
    end else begin
      state_q <= state_d;
      err_q   <= err_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    err_d      = err_q;
    in_ready_o = 1'b0;
    cmd_o.op   = DP_NOP;
    cmd_o.err  = err_q;
    case (state_q)
      S_CLEAR: begin
        cmd_o.op = DP_CLR_STEP;
        if (sts_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = DP_LOAD;
          state_d  = S_DECODE;
        end
      end
      S_DECODE: begin
        if (sts_i.bad_order) begin
          err_d   = ST_BAD_ORDER;
          state_d = S_ERR;
        end else if (!sts_i.is_free_req) begin
          state_d = S_A_RD;
        end else if (sts_i.bad_free) begin
          err_d   = ST_BAD_FREE;
          state_d = S_ERR;
        end else begin
          cmd_o.op = DP_FCHK_INIT;
          state_d  = S_F_RD;
        end
      end
      S_A_RD: begin
        if (sts_i.m_over) begin
          err_d   = ST_NO_MEM;
          state_d = S_ERR;
        end else begin
          cmd_o.op = DP_READ;
          state_d  = S_A_CHK;
        end
      end
      S_A_CHK: begin
        if (sts_i.word_nz) begin
          cmd_o.op = DP_FOUND;
          state_d  = S_SPLIT;
        end else begin
          cmd_o.op = DP_SCAN_NEXT;
          state_d  = S_A_RD;
        end
      end
      S_SPLIT: begin
        if (sts_i.m_at_ord) begin
          state_d = S_OK;
        end else begin
          cmd_o.op = DP_SPLIT;
          state_d  = S_SPL_RD;
        end
      end
      S_SPL_RD: begin
        cmd_o.op = DP_READ;
        state_d  = S_SPL_WR;
      end
      S_SPL_WR: begin
        cmd_o.op = DP_SET_BUDDY;
        state_d  = S_SPLIT;
      end
      S_F_RD: begin
        cmd_o.op = DP_READ;
        state_d  = S_F_CHK;
      end
      S_F_CHK: begin
        if (sts_i.hit) begin
          err_d   = ST_BAD_FREE;
          state_d = S_ERR;
        end else if (sts_i.row_end && sts_i.m_at_max) begin
          cmd_o.op = DP_MERGE_INIT;
          state_d  = S_M_TEST;
        end else begin
          cmd_o.op = DP_FCHK_NEXT;
          state_d  = S_F_RD;
        end
      end
      S_M_TEST: begin
        cmd_o.op = DP_READ;
        state_d  = sts_i.m_at_max ? S_M_SET : S_M_CHK;
      end
      S_M_CHK: begin
        if (sts_i.buddy_free) begin
          cmd_o.op = DP_CLR_BUDDY;
          state_d  = S_M_RD;
        end else begin
          cmd_o.op = DP_SET_SELF;
          state_d  = S_OK;
        end
      end
      S_M_RD: begin
        state_d = S_M_TEST;
      end
      S_M_SET: begin
        cmd_o.op = DP_SET_SELF;
        state_d  = S_OK;
      end
      S_OK: begin
        if (sts_i.out_free) begin
          cmd_o.op = DP_RES_OK;
          state_d  = S_IDLE;
        end
      end
      S_ERR: begin
        if (sts_i.out_free) begin
          cmd_o.op = DP_RES_ERR;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ hdl/buddy_page_allocator.sv @@
// Top level of the buddy page allocator: controller plus datapath.
// Uses bpa_pkg, bpa_ctrl and bpa_datapath (which holds bpa_ram).
`default_nettype none

// The allocator keeps one free bit for every block of every order from 0 to
// MAX_ORDER over NUM_PAGES pages, in a single-port memory of 64-bit words with
// one region per order. Each request transfer yields exactly one result
// transfer. After reset a clearing pass writes every memory word once, and no
// request is taken until it ends. An allocate scans the words of the requested
// order and of each larger order in turn until a free bit turns up, then splits
// the block one level at a time down to the requested order; a free checks
// every word that overlaps the block at every order and then merges the block
// with its buddy for as long as the buddy is free and the top is not reached.
// Requests that fail a range check go straight to the error result. The result
// sits in an output register, so a new request is taken as soon as the previous
// one has written its result, even if that result has not yet been transferred.
module buddy_page_allocator import bpa_pkg::*; #(
  parameter int unsigned MAX_ORDER = 10,
  parameter int unsigned NUM_PAGES = 4096
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire bpa_req_t in_data_i,
  output logic          out_valid_o,
  input  wire logic     out_ready_i,
  output bpa_rsp_t      out_data_o
);

  bpa_cmd_t cmd;
  bpa_sts_t sts;

  bpa_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .sts_i     (sts),
    .in_ready_o(in_ready_o),
    .cmd_o     (cmd)
  );

  bpa_datapath #(
    .MAX_ORDER(MAX_ORDER),
    .NUM_PAGES(NUM_PAGES)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .out_ready_i(out_ready_i),
    .sts_o      (sts),
    .out_valid_o(out_valid_o),
    .out_data_o (out_data_o)
  );

  // A result is only written when the output register is free or draining.
  a_res_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.op == DP_RES_OK || cmd.op == DP_RES_ERR) |-> sts.out_free)
    else $error("result written over a pending result");

  // Every request transfer loads the datapath registers.
  a_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |-> cmd.op == DP_LOAD)
    else $error("request transfer without load");

  // A successful block starts on a multiple of its own size.
  a_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.status == ST_OK) |->
      ((32'(out_data_o.page_index) & ((32'd1 << out_data_o.result_order) - 32'd1)) == 32'd0))
    else $error("misaligned result block");

  // A failed request reports neither page nor order.
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.status != ST_OK) |->
      (out_data_o.page_index == '0 && out_data_o.result_order == '0))
    else $error("error result carries page or order");

endmodule

`default_nettype wire

@@ dv/buddy_page_allocator_tb.sv @@
// Self-checking testbench of the buddy page allocator: random and directed
// allocate/free traffic, predicted by a behavioral free map. Uses bpa_pkg.
`default_nettype none

module buddy_page_allocator_tb;
  import bpa_pkg::*;

  localparam int unsigned MAX_ORD   = 10;
  localparam int unsigned PAGES     = 4096;
  // Idle cycles without a transfer before the run is declared hung.
  localparam int unsigned HANG_LIMIT = 20000;

  logic     clk_i;
  logic     rst_ni;
  logic     in_valid_i;
  logic     in_ready_o;
  bpa_req_t in_data_i;
  logic     out_valid_o;
  logic     out_ready_i;
  bpa_rsp_t out_data_o;

  buddy_page_allocator #(
    .MAX_ORDER(MAX_ORD),
    .NUM_PAGES(PAGES)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Behavioral copy of the free map: one bit per block per order.
  bit free_map [0:MAX_ORD][0:PAGES-1];

  bpa_rsp_t expected_rsps[$];
  int       error_count;
  int       idle_cycles;
  bit       rx_long_stalls;
  // Remaining cycles of a long stall on the result side.
  int       rx_hold;

  // Pages handed out by successful allocates, kept so most frees are legal.
  typedef struct {
    logic [PAGE_W-1:0]  page;
    logic [ORDER_W-1:0] ord;
  } held_block_t;
  held_block_t held_blocks[$];

  function automatic bit map_free(int k, int idx);
    if (k > MAX_ORD || idx >= (PAGES >> k)) begin
      return 1'b0;
    end
    return free_map[k][idx];
  endfunction

  function automatic void reset_map();
    for (int k = 0; k <= MAX_ORD; k++) begin
      for (int i = 0; i < PAGES; i++) begin
        free_map[k][i] = (k == MAX_ORD) && (i < (PAGES >> MAX_ORD));
      end
    end
  endfunction

  // Computes the response of the allocator to one request and updates the map.
  function automatic bpa_rsp_t predict_alloc_free(bpa_req_t req);
    bpa_rsp_t rsp;
    int       ord;
    int       page;
    int       m;
    int       idx;
    int       size;
    bit       found;
    bit       clash;
    rsp  = '0;
    ord  = req.order;
    page = req.block_index;
    if (ord > MAX_ORD) begin
      rsp.status = ST_BAD_ORDER;
      return rsp;
    end
    if (req.kind == KIND_ALLOC) begin
      found = 1'b0;
      idx   = 0;
      for (m = ord; m <= MAX_ORD; m++) begin
        for (int i = 0; i < (PAGES >> m); i++) begin
          if (free_map[m][i]) begin
            idx   = i;
            found = 1'b1;
            break;
          end
        end
        if (found) begin
          break;
        end
      end
      if (!found) begin
        rsp.status = ST_NO_MEM;
        return rsp;
      end
      free_map[m][idx] = 1'b0;
      while (m > ord) begin
        m--;
        idx = idx * 2;
        free_map[m][idx + 1] = 1'b1;
      end
      rsp.status       = ST_OK;
      rsp.page_index   = idx << ord;
      rsp.result_order = ord;
      return rsp;
    end
    size = 1 << ord;
    clash = ((page & (size - 1)) != 0) || (page + size > PAGES);
    for (int k = ord; k <= MAX_ORD && !clash; k++) begin
      if (map_free(k, page >> k)) begin
        clash = 1'b1;
      end
    end
    for (int k = 0; k < ord && !clash; k++) begin
      for (int j = 0; j < (1 << (ord - k)); j++) begin
        if (map_free(k, (page >> k) + j)) begin
          clash = 1'b1;
        end
      end
    end
    if (clash) begin
      rsp.status = ST_BAD_FREE;
      return rsp;
    end
    idx = page >> ord;
    m   = ord;
    while (m < MAX_ORD && map_free(m, idx ^ 1)) begin
      free_map[m][idx ^ 1] = 1'b0;
      idx = idx >> 1;
      m++;
    end
    free_map[m][idx]  = 1'b1;
    rsp.status       = ST_OK;
    rsp.page_index   = idx << m;
    rsp.result_order = m;
    return rsp;
  endfunction

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) begin
      return 0;
    end else if (roll < 93) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  // Sends one request, holding it until the transfer, and records the
  // predicted result at the transfer.
  task automatic send_request(logic kind, logic [ORDER_W-1:0] ord,
                              logic [PAGE_W-1:0] page, bit with_gaps);
    bpa_req_t req;
    bpa_rsp_t rsp;
    int       gap;
    req.kind        = kind;
    req.order       = ord;
    req.block_index = page;
    gap = with_gaps ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= req;
    @(posedge clk_i);
    while (!in_ready_o) begin
      @(posedge clk_i);
    end
    rsp = predict_alloc_free(req);
    expected_rsps.push_back(rsp);
    if (rsp.status == ST_OK && kind == KIND_ALLOC) begin
      held_blocks.push_back('{rsp.page_index, rsp.result_order});
    end
  endtask

  task automatic drop_input();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic wait_drained();
    while (expected_rsps.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  // Frees a randomly chosen held block; ignores the order of retrieval.
  task automatic free_held(bit with_gaps);
    int          sel;
    held_block_t blk;
    sel = $urandom_range(0, held_blocks.size() - 1);
    blk = held_blocks[sel];
    held_blocks.delete(sel);
    send_request(KIND_FREE, blk.ord, blk.page, with_gaps);
  endtask

  // Result side: random stalls and comparison against the oldest prediction.
  always @(posedge clk_i) begin
    bpa_rsp_t want;
    int       roll;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (expected_rsps.size() == 0) begin
          $error("result transfer with no request pending: %p", out_data_o);
          error_count++;
        end else begin
          want = expected_rsps.pop_front();
          if (out_data_o.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status,
                   out_data_o.status);
            error_count++;
          end
          if (out_data_o.page_index !== want.page_index) begin
            $error("page_index: expected %0d, actual %0d", want.page_index,
                   out_data_o.page_index);
            error_count++;
          end
          if (out_data_o.result_order !== want.result_order) begin
            $error("result_order: expected %0d, actual %0d", want.result_order,
                   out_data_o.result_order);
            error_count++;
          end
        end
      end
      roll = $urandom_range(0, 99);
      if (!rx_long_stalls) begin
        out_ready_i <= 1'b1;
      end else if (rx_hold > 0) begin
        rx_hold--;
        out_ready_i <= 1'b0;
      end else if (roll < 60) begin
        out_ready_i <= 1'b1;
      end else if (roll < 97) begin
        out_ready_i <= 1'b0;
      end else begin
        // A few stalls last for many cycles.
        rx_hold     = $urandom_range(8, 40);
        out_ready_i <= 1'b0;
      end
    end
  end

  // Watchdog on cycles with no transfer on either side.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles > HANG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Range checks on both fields and orders past the top.
  task automatic test_range_errors();
    send_request(KIND_ALLOC, 4'd11, 12'h000, 1'b0);
    send_request(KIND_ALLOC, 4'd15, 12'hFFF, 1'b0);
    send_request(KIND_FREE, 4'd15, 12'h000, 1'b0);
    send_request(KIND_FREE, 4'd3, 12'h001, 1'b0);
    send_request(KIND_FREE, 4'd0, 12'hFFF, 1'b0);
    send_request(KIND_FREE, 4'd10, 12'hC00, 1'b0);
    send_request(KIND_FREE, 4'd10, 12'hF00, 1'b0);
  endtask

  // Rebuilds nothing but clears bookkeeping; the map is the authority.
  function automatic void reset_held_from_map();
    held_blocks.delete();
  endfunction

  // Smallest and largest allocations, splits, frees with merging of free
  // buddies, and a double free.
  task automatic test_split_merge();
    send_request(KIND_ALLOC, 4'd0, 12'hABC, 1'b0);
    send_request(KIND_ALLOC, 4'd10, 12'h000, 1'b0);
    send_request(KIND_ALLOC, 4'd5, 12'h000, 1'b0);
    send_request(KIND_FREE, 4'd0, 12'h000, 1'b0);
    send_request(KIND_FREE, 4'd0, 12'h000, 1'b0);
    send_request(KIND_FREE, 4'd0, 12'h001, 1'b0);
    send_request(KIND_FREE, 4'd10, 12'h400, 1'b0);
    drop_input();
    wait_drained();
    held_blocks.delete();
    reset_held_from_map();
  endtask

  // Exhausts memory so out-of-memory is reported, then returns everything.
  task automatic test_exhaustion();
    for (int i = 0; i < 40; i++) begin
      send_request(KIND_ALLOC, 4'(i < 3 ? 10 : $urandom_range(6, 9)),
                   12'($urandom), 1'b1);
    end
    send_request(KIND_ALLOC, 4'd0, 12'h000, 1'b1);
    while (held_blocks.size() != 0) begin
      free_held(1'b1);
    end
    drop_input();
    wait_drained();
  endtask

  // Random traffic: mostly allocations of small orders and frees of held
  // blocks, with a share of bad-order allocations and of malformed and random frees.
  task automatic test_random_traffic(int count);
    int roll;
    for (int n = 0; n < count; n++) begin
      roll = $urandom_range(0, 99);
      if (n == count / 2) begin
        drop_input();
        wait_drained();
      end
      if (roll < 45) begin
        send_request(KIND_ALLOC,
                     4'($urandom_range(0, 9) < 8 ? $urandom_range(0, 4)
                                                 : $urandom_range(0, 15)),
                     12'($urandom), 1'b1);
      end else if (roll < 85 && held_blocks.size() != 0) begin
        free_held(1'b1);
      end else begin
        send_request(KIND_FREE, 4'($urandom_range(0, 11)), 12'($urandom), 1'b1);
      end
    end
    drop_input();
  endtask

  initial begin
    error_count    = 0;
    idle_cycles    = 0;
    rx_long_stalls = 1'b0;
    rx_hold        = 0;
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    in_data_i      = '0;
    out_ready_i    = 1'b1;
    reset_map();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_range_errors();
    test_split_merge();
    rx_long_stalls = 1'b1;
    test_exhaustion();
    test_random_traffic(1200);
    wait_drained();
    repeat (400) @(posedge clk_i);
    if (error_count == 0 && expected_rsps.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

`default_nettype wire
